// ===== rtl/rhm_pkg.sv =====
// Package with the sizes, constants and shared types of the running histogram median block.
`default_nettype none
package rhm_pkg;
	localparam int BINS = 256;
	localparam int COUNT_BITS = 16;
	localparam int BIN_W = $clog2(BINS);
	localparam int VAL_W = 12;
	localparam int RATIO_W = 17;
	localparam int THR_W = COUNT_BITS + 1;
	localparam int SUM_W = COUNT_BITS + 2;
	localparam int SCAN_W = $clog2(BINS + 2);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(655);
	localparam logic [7:0] HALF_FALLBACK = 8'(BINS / 2);

	typedef struct packed {
		logic en;
		logic ins_en;
		logic [BIN_W-1:0] ins_bin;
		logic rem_en;
		logic [BIN_W-1:0] rem_bin;
	} rhm_upd_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic found;
		logic [7:0] idx;
		logic err;
	} rhm_wave_t;

	function automatic logic [BIN_W-1:0] clamp_bin(input logic signed [VAL_W-1:0] v);
		logic signed [VAL_W:0] w;
		logic [BIN_W-1:0] r;
		w = {v[VAL_W-1], v};
		if (w < 0) begin
			r = '0;
		end else if (w > $signed((VAL_W+1)'(BINS - 1))) begin
			r = BIN_W'(BINS - 1);
		end else begin
			r = BIN_W'(w);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/rhm_if.sv =====
// Handshake interfaces for the sample, result and configuration channels.
`default_nettype none
interface rhm_in_if;
	logic valid;
	logic ready;
	logic insert_valid;
	logic signed [11:0] insert_value;
	logic remove_valid;
	logic signed [11:0] remove_value;
	modport source (output valid, insert_valid, insert_value, remove_valid, remove_value,
		input ready);
	modport sink (input valid, insert_valid, insert_value, remove_valid, remove_value,
		output ready);
endinterface

interface rhm_out_if;
	logic valid;
	logic ready;
	logic [7:0] median_bin;
	logic [7:0] top_bin;
	logic [15:0] sample_total;
	logic range_error;
	modport source (output valid, median_bin, top_bin, sample_total, range_error,
		input ready);
	modport sink (input valid, median_bin, top_bin, sample_total, range_error,
		output ready);
endinterface

interface rhm_cfg_if;
	logic valid;
	logic ready;
	logic [16:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rhm_cell.sv =====
// One histogram bin: its count and its stage of the upward and downward prefix-sum waves.
`default_nettype none
module rhm_cell (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [rhm_pkg::BIN_W-1:0] my_idx,
	input  wire rhm_pkg::rhm_upd_t upd,
	input  wire logic [rhm_pkg::COUNT_BITS-1:0] half,
	input  wire logic [rhm_pkg::THR_W-1:0] thr,
	input  wire rhm_pkg::rhm_wave_t lo_in,
	input  wire rhm_pkg::rhm_wave_t hi_in,
	output rhm_pkg::rhm_wave_t lo_out,
	output rhm_pkg::rhm_wave_t hi_out
);
	import rhm_pkg::*;

	logic [COUNT_BITS-1:0] cnt_q;
	logic err_q;
	logic [COUNT_BITS-1:0] cnt_n;
	logic err_n;
	rhm_wave_t lo_n, hi_n, lo_q, hi_q;
	logic [SUM_W-1:0] lo_s, hi_s;

	always_comb begin
		cnt_n = cnt_q;
		err_n = 1'b0;
		if (upd.ins_en && upd.ins_bin == my_idx) begin
			if (cnt_n == CNT_MAX) err_n = 1'b1;
			else cnt_n = cnt_n + 1'b1;
		end
		if (upd.rem_en && upd.rem_bin == my_idx) begin
			if (cnt_n == '0) err_n = 1'b1;
			else cnt_n = cnt_n - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= 1'b0;
		end else if (upd.en) begin
			cnt_q <= cnt_n;
			err_q <= err_n;
		end
	end

	assign lo_s = lo_in.sum + SUM_W'(cnt_q);
	assign hi_s = hi_in.sum + SUM_W'(cnt_q);

	always_comb begin
		lo_n = lo_in;
		lo_n.err = lo_in.err | err_q;
		if (!lo_in.found) begin
			lo_n.sum = lo_s;
			if (lo_s >= SUM_W'(half)) begin
				lo_n.found = 1'b1;
				lo_n.idx = 8'(my_idx);
			end
		end
		hi_n = hi_in;
		if (!hi_in.found) begin
			hi_n.sum = hi_s;
			if (hi_s >= SUM_W'(thr)) begin
				hi_n.found = 1'b1;
				hi_n.idx = 8'(my_idx);
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= lo_n;
		hi_q <= hi_n;
	end

	assign lo_out = lo_q;
	assign hi_out = hi_q;
endmodule
`default_nettype wire

// ===== rtl/running_histogram_median_core.sv =====
// Top level: request control, total and thresholds, and the row of bin cells.
//
// Channel     Direction  Payload
// sample_in   in         insert_valid, insert_value, remove_valid, remove_value
// result_out  out        median_bin, top_bin, sample_total, range_error
// cfg         in         top_ratio (17 bits)
//
// Each request runs through the states in order: ST_IDLE takes it, ST_UPD updates
// the bins and the total, ST_THR registers the threshold multiply, ST_SCAN runs while
// the two prefix-sum waves cross the row of bin cells, and ST_DONE loads the result.
// Reset clears all bins at once. A result waits in the output register and the
// next request is taken meanwhile; its result stalls until the first is taken.
`default_nettype none
module running_histogram_median_core (
	input  wire logic clk,
	input  wire logic arst_n,
	rhm_in_if.sink sample_in,
	rhm_out_if.source result_out,
	rhm_cfg_if.sink cfg
);
	import rhm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_THR  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [SCAN_W-1:0] scan_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [COUNT_BITS-1:0] total_q, half_q, total_n;
	logic [THR_W-1:0] thr_q, thr_raw;
	logic tot_err_q, tot_err_n;
	logic ins_en_q, rem_en_q;
	logic [BIN_W-1:0] ins_bin_q, rem_bin_q;
	logic [RATIO_W+COUNT_BITS-1:0] prod;
	rhm_upd_t upd;
	rhm_wave_t lo_w [BINS+1];
	rhm_wave_t hi_w [BINS+1];
	logic out_valid_q;
	logic done_fire;
	logic [7:0] med_q, top_q;
	logic [15:0] tot_out_q;
	logic err_out_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ratio_q <= RATIO_RESET;
		else if (cfg.valid) ratio_q <= cfg.data;
	end

	assign sample_in.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (sample_in.valid && sample_in.ready) begin
			ins_en_q <= sample_in.insert_valid;
			rem_en_q <= sample_in.remove_valid;
			ins_bin_q <= clamp_bin(sample_in.insert_value);
			rem_bin_q <= clamp_bin(sample_in.remove_value);
		end
	end

	assign upd.en = (state_q == ST_UPD);
	assign upd.ins_en = ins_en_q;
	assign upd.ins_bin = ins_bin_q;
	assign upd.rem_en = rem_en_q;
	assign upd.rem_bin = rem_bin_q;

	always_comb begin
		total_n = total_q;
		tot_err_n = 1'b0;
		if (ins_en_q) begin
			if (total_n == CNT_MAX) tot_err_n = 1'b1;
			else total_n = total_n + 1'b1;
		end
		if (rem_en_q) begin
			if (total_n == '0) tot_err_n = 1'b1;
			else total_n = total_n - 1'b1;
		end
	end

	assign prod = ratio_q * total_q;
	assign thr_raw = prod[16 +: THR_W];

	assign done_fire = (state_q == ST_DONE) && (!out_valid_q || result_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q <= '0;
			total_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sample_in.valid) state_q <= ST_UPD;
				end
				ST_UPD: begin
					total_q <= total_n;
					state_q <= ST_THR;
				end
				ST_THR: begin
					scan_q <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == SCAN_W'(BINS)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (done_fire) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) tot_err_q <= tot_err_n;
		if (state_q == ST_THR) begin
			half_q <= total_q >> 1;
			thr_q <= (thr_raw == '0) ? THR_W'(1) : thr_raw;
		end
		if (done_fire) begin
			med_q <= lo_w[BINS].found ? lo_w[BINS].idx : HALF_FALLBACK;
			top_q <= hi_w[0].found ? hi_w[0].idx : 8'd0;
			tot_out_q <= 16'(total_q);
			err_out_q <= lo_w[BINS].err | tot_err_q;
		end
	end

	assign lo_w[0] = '0;
	assign hi_w[BINS] = '0;

	for (genvar i = 0; i < BINS; i++) begin : g_cell
		rhm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.my_idx (BIN_W'(i)),
			.upd    (upd),
			.half   (half_q),
			.thr    (thr_q),
			.lo_in  (lo_w[i]),
			.hi_in  (hi_w[i+1]),
			.lo_out (lo_w[i+1]),
			.hi_out (hi_w[i])
		);
	end

	assign result_out.valid = out_valid_q;
	assign result_out.median_bin = med_q;
	assign result_out.top_bin = top_q;
	assign result_out.sample_total = tot_out_q;
	assign result_out.range_error = err_out_q;
endmodule
`default_nettype wire
